// ===== rtl/core/apra_pkg.sv =====
`timescale 1ns / 1ps

package apra_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W = 32;
    localparam int FIELD_W = 7;
    localparam logic [FIELD_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic
    {
        OP_PUSH   = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_DONE = 1'b0,
        ST_FULL = 1'b1
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_PUSH,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed
    {
        op_t                operation;
        logic signed [31:0] value;
    } item_t;

    typedef struct packed
    {
        status_t            status;
        logic [FIELD_W-1:0] removed_count;
        logic [FIELD_W-1:0] fill_count;
    } result_t;

    typedef struct packed
    {
        logic load;
        logic push;
        logic scan;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/array_push_remove_all.sv =====
`timescale 1ns / 1ps
// A push passes through the S_PUSH and S_FINISH states before its result is registered.
// A remove stays in the S_SCAN state while it compacts the N entries held, then S_FINISH registers its result;
// the compaction reads one entry per cycle and writes back each entry that does not match.
// Throughput: one item at a time; the next input transfer is taken at the clock edge after
// the one that registers the result, even while that result is stalled.
// Reset clears the fill count and sets the capacity to 64; entry contents are not cleared.

module array_push_remove_all
    import apra_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  item_t              item,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    apra_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_op    (item.operation),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    apra_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/core/apra_ctrl.sv =====
`timescale 1ns / 1ps

module apra_ctrl
    import apra_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  op_t        item_op,
    output logic       item_stall,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (item_op == OP_PUSH) ? S_PUSH : S_SCAN;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_FINISH;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && stat.out_free) |=> (state_reg == S_IDLE))
        else $error("Controller did not return to idle after the result transfer.");
`endif

endmodule

// ===== rtl/core/apra_dp.sv =====
`timescale 1ns / 1ps

module apra_dp
    import apra_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic               cfg_valid,
    input  logic [FIELD_W-1:0] cfg_data,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    output logic               result_valid,
    input  logic               result_stall,
    output result_t            result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WORD_W-1:0]  mem [DEPTH];

    logic [FIELD_W-1:0] capacity_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      rd_reg;
    logic [CW-1:0]      wr_reg;
    logic [CW-1:0]      removed_reg;
    logic               pend_reg;
    op_t                op_reg;
    logic [WORD_W-1:0]  val_reg;
    logic [WORD_W-1:0]  rdata_reg;
    logic               fail_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic               full;
    logic               rd_more;
    logic               match;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;

    assign full    = (32'(count_reg) >= 32'(capacity_reg)) || (32'(count_reg) == 32'(DEPTH));
    assign rd_more = (rd_reg != count_reg);
    assign match   = (rdata_reg == val_reg);

    assign stat.scan_done = !rd_more && !pend_reg;
    assign stat.out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        if (cmd.push && !full)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.scan && pend_reg && !match)
        begin
            mem_we    = 1'b1;
            mem_waddr = wr_reg[AW-1:0];
        end
    end

    always_comb
    begin
        if (op_reg == OP_REMOVE)
        begin
            count_next = wr_reg;
        end
        else if (fail_reg)
        begin
            count_next = count_reg;
        end
        else
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= cmd.push ? val_reg : rdata_reg;
        end
        if (cmd.scan && rd_more)
        begin
            rdata_reg <= mem[rd_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= item.operation;
            val_reg <= item.value;
        end
        if (cmd.push)
        begin
            fail_reg <= full;
        end
        if (cmd.finish)
        begin
            out_reg.status        <= (op_reg == OP_PUSH && fail_reg) ? ST_FULL : ST_DONE;
            out_reg.removed_count <= (op_reg == OP_REMOVE) ? FIELD_W'(removed_reg) : '0;
            out_reg.fill_count    <= FIELD_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            removed_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                capacity_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                rd_reg      <= '0;
                wr_reg      <= '0;
                removed_reg <= '0;
                pend_reg    <= 1'b0;
            end
            else if (cmd.scan)
            begin
                pend_reg <= rd_more;
                if (rd_more)
                begin
                    rd_reg <= rd_reg + CW'(1);
                end
                if (pend_reg)
                begin
                    if (match)
                    begin
                        removed_reg <= removed_reg + CW'(1);
                    end
                    else
                    begin
                        wr_reg <= wr_reg + CW'(1);
                    end
                end
            end
            if (cmd.finish)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= 32'(DEPTH))
        else $error("Fill count exceeds the array depth.");

    a_scan_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(removed_reg) + 32'(wr_reg) + 32'(pend_reg)) == 32'(rd_reg))
        else $error("Scan counters are out of balance.");

    a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
        wr_reg <= rd_reg)
        else $error("Compaction write index passed the read index.");
`endif

endmodule
